// ===== rtl/clnw_pkg.sv =====
// Shared types, command constants and sequencing functions for the character LCD
// nibble writer. Used by clnw_seq, char_lcd_nibble_writer and the testbench; depends on nothing.
package clnw_pkg;

	localparam int CfgIdxW = 3;
	localparam int TickW   = 16;

	// Request codes carried in the mode field.
	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_DATA   = 3'd1;
	localparam logic [2:0] MODE_CMD    = 3'd2;
	localparam logic [2:0] MODE_INIT   = 3'd3;
	localparam logic [2:0] MODE_CURSOR = 3'd4;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_ENABLE_PULSE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_NIBBLE_GAP   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SHORT_WAIT   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LONG_WAIT    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_INIT_NWAIT   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_POWER_UP     = 3'd5;

	// Display commands and wake-up nibbles.
	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_HOME      = 8'h02;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [3:0] NIB_WAKE      = 4'h3;
	localparam logic [3:0] NIB_4BIT      = 4'h2;

	// Init sequence step markers.
	localparam logic [3:0] STEP_NONE       = 4'd0;
	localparam logic [3:0] STEP_POWER      = 4'd1;
	localparam logic [3:0] STEP_WAKE_FIRST = 4'd2;
	localparam logic [3:0] STEP_WAKE_LAST  = 4'd4;
	localparam logic [3:0] STEP_FUNC_NIB   = 4'd5;
	localparam logic [3:0] STEP_CMD_FIRST  = 4'd6;
	localparam logic [3:0] STEP_CMD_MORE   = 4'd8;
	localparam logic [3:0] STEP_CMD_LAST   = 4'd9;
	localparam logic [3:0] STEP_FINAL      = 4'd10;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_POWER,
		PH_EN,
		PH_GAP,
		PH_NWAIT,
		PH_BWAIT,
		PH_FINAL
	} phase_t;

	typedef struct packed {
		logic [TickW-1:0] enable_pulse_ticks;
		logic [TickW-1:0] nibble_gap_ticks;
		logic [TickW-1:0] short_wait_ticks;
		logic [TickW-1:0] long_wait_ticks;
		logic [TickW-1:0] init_nibble_wait_ticks;
		logic [TickW-1:0] power_up_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] byte_value;
		logic [1:0] cursor_row;
		logic [5:0] cursor_col;
	} item_t;

	typedef struct packed {
		logic       accepted;
		logic       busy_res;
		logic [3:0] data_nibble;
		logic       enable_pin;
		logic       reg_select;
	} res_t;

	typedef struct packed {
		phase_t           phase;
		logic [TickW-1:0] delay_count;
		logic [7:0]       byte_latch;
		logic             low_half_pending;
		logic [3:0]       init_step;
		logic             rs_level;
		logic             enable_level;
		logic [3:0]       nibble_out;
	} ctl_state_t;

	function automatic logic [7:0] row_base(input logic [1:0] row);
		case (row)
			2'd0:    row_base = 8'h00;
			2'd1:    row_base = 8'h40;
			2'd2:    row_base = 8'h14;
			default: row_base = 8'h54;
		endcase
	endfunction

	function automatic logic [7:0] init_cmd(input logic [1:0] idx);
		case (idx)
			2'd0:    init_cmd = 8'h28;
			2'd1:    init_cmd = 8'h0C;
			2'd2:    init_cmd = 8'h01;
			default: init_cmd = 8'h06;
		endcase
	endfunction

	function automatic ctl_state_t start_nibble(input ctl_state_t s, input logic [3:0] nib,
			input cfg_t c);
		ctl_state_t n;
		n = s;
		n.nibble_out   = nib;
		n.enable_level = 1'b1;
		n.phase        = PH_EN;
		// An enable time of zero is stretched to one tick.
		n.delay_count  = (c.enable_pulse_ticks == '0) ? TickW'(1) : c.enable_pulse_ticks;
		return n;
	endfunction

	function automatic ctl_state_t start_byte(input ctl_state_t s, input logic [7:0] b,
			input logic rs, input cfg_t c);
		ctl_state_t n;
		n = s;
		n.byte_latch       = b;
		n.rs_level         = rs;
		n.low_half_pending = 1'b1;
		return start_nibble(n, b[7:4], c);
	endfunction

	// Leave the current phase, whose time is over, and enter the next one.
	function automatic ctl_state_t advance(input ctl_state_t s, input cfg_t c);
		ctl_state_t n;
		logic [3:0] step_inc;
		logic [3:0] cmd_idx;
		n        = s;
		step_inc = s.init_step + 4'd1;
		cmd_idx  = step_inc - STEP_CMD_FIRST;
		case (s.phase)
			PH_POWER: begin
				n.init_step = STEP_WAKE_FIRST;
				n = start_nibble(n, NIB_WAKE, c);
			end
			PH_EN: begin
				n.enable_level = 1'b0;
				n.phase        = PH_GAP;
				n.delay_count  = c.nibble_gap_ticks;
			end
			PH_GAP: begin
				if (s.init_step >= STEP_WAKE_FIRST && s.init_step <= STEP_FUNC_NIB) begin
					n.phase       = PH_NWAIT;
					n.delay_count = c.init_nibble_wait_ticks;
				end else if (s.low_half_pending) begin
					n.low_half_pending = 1'b0;
					n = start_nibble(n, s.byte_latch[3:0], c);
				end else begin
					n.phase = PH_BWAIT;
					if (!s.rs_level && (s.byte_latch == CMD_CLEAR || s.byte_latch == CMD_HOME))
						n.delay_count = c.long_wait_ticks;
					else
						n.delay_count = c.short_wait_ticks;
				end
			end
			PH_NWAIT: begin
				n.init_step = step_inc;
				if (step_inc <= STEP_WAKE_LAST) begin
					n = start_nibble(n, NIB_WAKE, c);
				end else if (step_inc == STEP_FUNC_NIB) begin
					n = start_nibble(n, NIB_4BIT, c);
				end else begin
					n.init_step = STEP_CMD_FIRST;
					n = start_byte(n, init_cmd(2'd0), 1'b0, c);
				end
			end
			PH_BWAIT: begin
				if (s.init_step >= STEP_CMD_FIRST && s.init_step <= STEP_CMD_MORE) begin
					n.init_step = step_inc;
					n = start_byte(n, init_cmd(cmd_idx[1:0]), 1'b0, c);
				end else if (s.init_step == STEP_CMD_LAST) begin
					n.init_step   = STEP_FINAL;
					n.phase       = PH_FINAL;
					n.delay_count = c.long_wait_ticks;
				end else begin
					n.init_step   = STEP_NONE;
					n.phase       = PH_IDLE;
					n.delay_count = '0;
				end
			end
			default: begin
				n.init_step   = STEP_NONE;
				n.phase       = PH_IDLE;
				n.delay_count = '0;
			end
		endcase
		return n;
	endfunction

	// Run through every phase that has expired. The enable phase always lasts at
	// least one tick, so at most four phases can end in one tick.
	function automatic ctl_state_t settle(input ctl_state_t s, input cfg_t c);
		ctl_state_t n;
		n = s;
		for (int i = 0; i < 4; i++) begin
			if (n.phase != PH_IDLE && n.delay_count == '0)
				n = advance(n, c);
		end
		return n;
	endfunction

endpackage

// ===== rtl/char_lcd_nibble_writer.sv =====
// Top level of the character LCD nibble writer: stream ports, configuration
// registers, input register and result register. Depends on clnw_pkg, clnw_seq.
//
// Usage: every transaction on the slave stream is one timing tick of an
// HD44780-style 4-bit display controller. Its mode field asks for nothing, a
// data byte, a command byte, the power-up initialization or a cursor move.
// For every input transaction exactly one result transaction leaves on the
// master stream, carrying the RS, E and D7..D4 pin levels after that tick,
// the busy flag and whether the tick's request was taken.
// A request that arrives while a sequence or wait is running is dropped and
// reported with accepted low.
// An item is held in the input register, and its result is loaded into the
// output register when that register is free to take it.
// Throughput is one item per clock unless results stall; the sequencer state
// advances once per item, so wall-clock time between ticks does not matter.
// When the master side stalls, the output register holds its result, the input
// register fills, and s_axis_tready falls until the result is taken.
// Reset clears the pipeline, sets the timing registers to their defaults and
// puts the sequencer in idle with all pins low. Configuration writes are meant
// for times when no sequence is running.
module char_lcd_nibble_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// mode[2:0], byte_value[10:3], cursor_row[12:11], cursor_col[18:13], zero fill
	input  logic [23:0]                   s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// reg_select[0], enable_pin[1], data_nibble[5:2], busy_res[6], accepted[7]
	output logic [7:0]                    m_axis_tdata,
	input  logic                          cfg_wr_en,
	input  logic [clnw_pkg::CfgIdxW-1:0]  cfg_addr,
	input  logic [clnw_pkg::TickW-1:0]    cfg_wdata
);
	import clnw_pkg::*;

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	logic  out_valid_q;
	res_t  out_res_q;
	res_t  res;
	logic  out_free;
	logic  step;
	logic  in_fire;

	// The output register can take a new result when it is empty or being drained.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Timing registers; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_pulse_ticks     <= TickW'(1);
			cfg_q.nibble_gap_ticks       <= TickW'(100);
			cfg_q.short_wait_ticks       <= TickW'(50);
			cfg_q.long_wait_ticks        <= TickW'(2000);
			cfg_q.init_nibble_wait_ticks <= TickW'(5000);
			cfg_q.power_up_ticks         <= TickW'(50000);
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_ENABLE_PULSE: cfg_q.enable_pulse_ticks     <= cfg_wdata;
				REG_NIBBLE_GAP:   cfg_q.nibble_gap_ticks       <= cfg_wdata;
				REG_SHORT_WAIT:   cfg_q.short_wait_ticks       <= cfg_wdata;
				REG_LONG_WAIT:    cfg_q.long_wait_ticks        <= cfg_wdata;
				REG_INIT_NWAIT:   cfg_q.init_nibble_wait_ticks <= cfg_wdata;
				REG_POWER_UP:     cfg_q.power_up_ticks         <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.mode       <= s_axis_tdata[2:0];
			item_s1.byte_value <= s_axis_tdata[10:3];
			item_s1.cursor_row <= s_axis_tdata[12:11];
			item_s1.cursor_col <= s_axis_tdata[18:13];
		end
	end

	clnw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			out_res_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_res_q;

`ifndef SYNTHESIS
	a_result_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !step)
		else $error("pending result overwritten");

	a_item_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> valid_s1 && $stable(item_s1))
		else $error("input item lost before processing");

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("processed item produced no result");
`endif

endmodule

// ===== rtl/clnw_seq.sv =====
// Display sequencer: holds the controller state and applies one tick per item.
// Depends on clnw_pkg for the state, config, item and result types.
module clnw_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  clnw_pkg::item_t item,
	input  clnw_pkg::cfg_t  cfg,
	output clnw_pkg::res_t  res
);
	import clnw_pkg::*;

	ctl_state_t st_q;
	ctl_state_t work;
	ctl_state_t nxt;
	logic       acc;
	logic [7:0] cursor_addr;

	assign cursor_addr = row_base(item.cursor_row) + {2'b00, item.cursor_col};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase            <= PH_IDLE;
			st_q.delay_count      <= '0;
			st_q.byte_latch       <= '0;
			st_q.low_half_pending <= 1'b0;
			st_q.init_step        <= STEP_NONE;
			st_q.rs_level         <= 1'b0;
			st_q.enable_level     <= 1'b0;
			st_q.nibble_out       <= '0;
		end else if (step) begin
			st_q <= nxt;
		end
	end

	always_comb begin
		work = st_q;
		if (work.phase != PH_IDLE) begin
			if (work.delay_count != '0)
				work.delay_count = work.delay_count - TickW'(1);
			work = settle(work, cfg);
		end
		nxt = work;
		acc = 1'b0;
		if (work.phase == PH_IDLE) begin
			case (item.mode)
				MODE_DATA: begin
					acc = 1'b1;
					nxt.init_step = STEP_NONE;
					nxt = start_byte(nxt, item.byte_value, 1'b1, cfg);
				end
				MODE_CMD: begin
					acc = 1'b1;
					nxt.init_step = STEP_NONE;
					nxt = start_byte(nxt, item.byte_value, 1'b0, cfg);
				end
				MODE_CURSOR: begin
					acc = 1'b1;
					nxt.init_step = STEP_NONE;
					nxt = start_byte(nxt, CMD_SET_DDRAM | cursor_addr, 1'b0, cfg);
				end
				MODE_INIT: begin
					acc = 1'b1;
					nxt.rs_level    = 1'b0;
					nxt.init_step   = STEP_POWER;
					nxt.phase       = PH_POWER;
					nxt.delay_count = cfg.power_up_ticks;
					// A zero power-up wait goes straight to the first wake-up nibble.
					if (cfg.power_up_ticks == '0)
						nxt = advance(nxt, cfg);
				end
				default: ;
			endcase
		end
	end

	assign res.reg_select  = nxt.rs_level;
	assign res.enable_pin  = nxt.enable_level;
	assign res.data_nibble = nxt.nibble_out;
	assign res.busy_res    = (nxt.phase != PH_IDLE);
	assign res.accepted    = acc;

`ifndef SYNTHESIS
	a_enable_only_in_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.enable_level |-> st_q.phase == PH_EN)
		else $error("enable high outside an enable phase");

	a_idle_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_IDLE |-> (st_q.delay_count == '0 && st_q.init_step == STEP_NONE
			&& !st_q.low_half_pending))
		else $error("idle with leftover sequence state");

	a_no_accept_mid_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(step && st_q.phase != PH_IDLE && st_q.delay_count > TickW'(1)) |-> !res.accepted)
		else $error("request taken while a phase still had time left");

	a_step_reaches_state: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> st_q.enable_level == $past(res.enable_pin)
			&& st_q.nibble_out == $past(res.data_nibble))
		else $error("reported pin levels differ from stored state");
`endif

endmodule

// ===== test/lcd_pin_checker.sv =====
// Pin-level predictor and result checker for the character LCD nibble writer.
// Depends on clnw_pkg for the phase type, request codes and register indexes.
module lcd_pin_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [23:0]                   in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [7:0]                    out_data,
	input  logic                          cfg_wr_en,
	input  logic [clnw_pkg::CfgIdxW-1:0]  cfg_addr,
	input  logic [clnw_pkg::TickW-1:0]    cfg_wdata,
	output int                            mismatches,
	output int                            pins_pending,
	output logic                          lcd_busy
);
	import clnw_pkg::*;

	localparam logic [15:0] DEF_PULSE = 16'd1;
	localparam logic [15:0] DEF_GAP   = 16'd100;
	localparam logic [15:0] DEF_SHORT = 16'd50;
	localparam logic [15:0] DEF_LONG  = 16'd2000;
	localparam logic [15:0] DEF_NWAIT = 16'd5000;
	localparam logic [15:0] DEF_POWER = 16'd50000;

	// Row start addresses 00/40/14/54 and the four init commands
	// (function set 4-bit, display on, clear, entry mode), lowest entry first.
	localparam logic [31:0] ROW_STARTS  = 32'h5414_4000;
	localparam logic [31:0] INIT_BYTES  = 32'h0601_0C28;

	phase_t      seq_phase;
	logic [15:0] tick_cnt;
	logic [7:0]  held_byte;
	logic        low_half_due;
	logic [3:0]  init_pos;
	logic        rs_pin;
	logic        e_pin;
	logic [3:0]  d_pins;
	logic [15:0] cfg_pulse, cfg_gap, cfg_short, cfg_long, cfg_nwait, cfg_power;
	logic [7:0]  pins_q[$];
	int          fails;

	function automatic void kick_nibble(input logic [3:0] n);
		d_pins    = n;
		e_pin     = 1'b1;
		seq_phase = PH_EN;
		tick_cnt  = (cfg_pulse == '0) ? 16'd1 : cfg_pulse;
	endfunction

	function automatic void load_byte(input logic [7:0] b, input logic rs);
		held_byte    = b;
		rs_pin       = rs;
		low_half_due = 1'b1;
		kick_nibble(b[7:4]);
	endfunction

	function automatic void phase_done();
		logic [3:0] cmd_pos;
		case (seq_phase)
			PH_POWER: begin
				init_pos = STEP_WAKE_FIRST;
				kick_nibble(NIB_WAKE);
			end
			PH_EN: begin
				e_pin     = 1'b0;
				seq_phase = PH_GAP;
				tick_cnt  = cfg_gap;
			end
			PH_GAP: begin
				if (init_pos >= STEP_WAKE_FIRST && init_pos <= STEP_FUNC_NIB) begin
					seq_phase = PH_NWAIT;
					tick_cnt  = cfg_nwait;
				end else if (low_half_due) begin
					low_half_due = 1'b0;
					kick_nibble(held_byte[3:0]);
				end else begin
					seq_phase = PH_BWAIT;
					// Only clear and home sent as commands earn the long wait.
					if (!rs_pin && (held_byte == CMD_CLEAR || held_byte == CMD_HOME))
						tick_cnt = cfg_long;
					else
						tick_cnt = cfg_short;
				end
			end
			PH_NWAIT: begin
				init_pos = init_pos + 4'd1;
				if (init_pos <= STEP_WAKE_LAST) begin
					kick_nibble(NIB_WAKE);
				end else if (init_pos == STEP_FUNC_NIB) begin
					kick_nibble(NIB_4BIT);
				end else begin
					init_pos = STEP_CMD_FIRST;
					load_byte(INIT_BYTES[7:0], 1'b0);
				end
			end
			PH_BWAIT: begin
				if (init_pos >= STEP_CMD_FIRST && init_pos <= STEP_CMD_MORE) begin
					init_pos = init_pos + 4'd1;
					cmd_pos  = init_pos - STEP_CMD_FIRST;
					load_byte(INIT_BYTES[{cmd_pos[1:0], 3'b000} +: 8], 1'b0);
				end else if (init_pos == STEP_CMD_LAST) begin
					init_pos  = STEP_FINAL;
					seq_phase = PH_FINAL;
					tick_cnt  = cfg_long;
				end else begin
					init_pos  = STEP_NONE;
					seq_phase = PH_IDLE;
					tick_cnt  = '0;
				end
			end
			default: begin
				init_pos  = STEP_NONE;
				seq_phase = PH_IDLE;
				tick_cnt  = '0;
			end
		endcase
	endfunction

	// Zero-length phases collapse into the same tick.
	function automatic void run_expired();
		while (seq_phase != PH_IDLE && tick_cnt == '0)
			phase_done();
	endfunction

	// One tick of the controller; returns {accepted, busy, D7..D4, E, RS}.
	function automatic logic [7:0] lcd_tick(input logic [2:0] mode, input logic [7:0] bv,
			input logic [1:0] row, input logic [5:0] col);
		logic       took;
		logic [7:0] addr;
		took = 1'b0;
		if (seq_phase != PH_IDLE) begin
			if (tick_cnt != '0)
				tick_cnt = tick_cnt - 16'd1;
			run_expired();
		end
		if (seq_phase == PH_IDLE && mode >= MODE_DATA && mode <= MODE_CURSOR) begin
			took     = 1'b1;
			init_pos = STEP_NONE;
			case (mode)
				MODE_DATA: load_byte(bv, 1'b1);
				MODE_CMD:  load_byte(bv, 1'b0);
				MODE_CURSOR: begin
					addr = ROW_STARTS[{row, 3'b000} +: 8] + {2'b00, col};
					load_byte(CMD_SET_DDRAM | addr, 1'b0);
				end
				default: begin
					rs_pin    = 1'b0;
					init_pos  = STEP_POWER;
					seq_phase = PH_POWER;
					tick_cnt  = cfg_power;
					run_expired();
				end
			endcase
		end
		return {took, seq_phase != PH_IDLE, d_pins, e_pin, rs_pin};
	endfunction

	function automatic void compare_pin(input string name, input logic [3:0] want,
			input logic [3:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		if (!arst_n) begin
			seq_phase    = PH_IDLE;
			tick_cnt     = '0;
			held_byte    = '0;
			low_half_due = 1'b0;
			init_pos     = STEP_NONE;
			rs_pin       = 1'b0;
			e_pin        = 1'b0;
			d_pins       = '0;
			cfg_pulse    = DEF_PULSE;
			cfg_gap      = DEF_GAP;
			cfg_short    = DEF_SHORT;
			cfg_long     = DEF_LONG;
			cfg_nwait    = DEF_NWAIT;
			cfg_power    = DEF_POWER;
			pins_q.delete();
			fails        = 0;
			mismatches   <= 0;
			pins_pending <= 0;
			lcd_busy     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_ENABLE_PULSE: cfg_pulse = cfg_wdata;
					REG_NIBBLE_GAP:   cfg_gap   = cfg_wdata;
					REG_SHORT_WAIT:   cfg_short = cfg_wdata;
					REG_LONG_WAIT:    cfg_long  = cfg_wdata;
					REG_INIT_NWAIT:   cfg_nwait = cfg_wdata;
					REG_POWER_UP:     cfg_power = cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pins_q.size() == 0) begin
					$display("%0t: result transaction with none expected, actual %h",
						$time, out_data);
					fails++;
				end else begin
					want = pins_q.pop_front();
					compare_pin("reg_select",  {3'b0, want[0]}, {3'b0, out_data[0]});
					compare_pin("enable_pin",  {3'b0, want[1]}, {3'b0, out_data[1]});
					compare_pin("data_nibble", want[5:2],       out_data[5:2]);
					compare_pin("busy_res",    {3'b0, want[6]}, {3'b0, out_data[6]});
					compare_pin("accepted",    {3'b0, want[7]}, {3'b0, out_data[7]});
				end
			end
			if (in_valid && in_ready)
				pins_q.push_back(lcd_tick(in_data[2:0], in_data[10:3], in_data[12:11],
					in_data[18:13]));
			mismatches   <= fails;
			pins_pending <= pins_q.size();
			lcd_busy     <= (seq_phase != PH_IDLE);
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Top of the character LCD nibble writer testbench: clock, reset, stimulus and verdict.
// Depends on clnw_pkg, char_lcd_nibble_writer and lcd_pin_checker.
module tb_top;
	import clnw_pkg::*;

	// Register indexes past the last timing register; writes to them must be dropped.
	localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;
	// Mode codes with no meaning; the block treats them as a plain tick.
	localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
	localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// mode[2:0], byte_value[10:3], cursor_row[12:11], cursor_col[18:13], zero fill
	logic [23:0]          s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// reg_select[0], enable_pin[1], data_nibble[5:2], busy_res[6], accepted[7]
	logic [7:0]           m_axis_tdata;
	logic                 cfg_wr_en = 1'b0;
	logic [CfgIdxW-1:0]   cfg_addr = '0;
	logic [TickW-1:0]     cfg_wdata = '0;

	int                   mismatches;
	int                   pins_pending;
	logic                 lcd_busy;
	// While set, neither side idles: the sender offers a transaction every cycle
	// and the receiver never stalls.
	bit                   calm = 1'b0;

	char_lcd_nibble_writer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	lcd_pin_checker pin_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_data      (s_axis_tdata),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_data     (m_axis_tdata),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.pins_pending (pins_pending),
		.lcd_busy     (lcd_busy)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// The receiver stalls at random with an 18 percent chance unless the run is calm.
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= 18);
	end

	// Offer one tick to the block and return at the edge where the transaction
	// is taken. Random idle cycles are inserted in front of it. All handshake
	// signals are read right after the edge, so they still hold their pre-edge
	// values because everything on both sides is updated by nonblocking writes.
	task automatic send_item(input logic [2:0] mode, input logic [7:0] bv,
			input logic [1:0] row, input logic [5:0] col);
		while (!calm && $urandom_range(99) < 18) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, col, row, bv, mode};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Send plain ticks until the predicted sequencer is idle. The busy flag seen
	// after an edge lags one transaction behind, which is why one tick goes out
	// first; with no requests among the ticks the flag can only fall, so a low
	// flag is never stale in the wrong direction.
	task automatic finish_sequence();
		send_item(MODE_TICK, 8'($urandom_range(255)), 2'($urandom_range(3)),
			6'($urandom_range(63)));
		while (lcd_busy)
			send_item(MODE_TICK, 8'($urandom_range(255)), 2'($urandom_range(3)),
				6'($urandom_range(63)));
	endtask

	// Hold the sender off until every expected result transaction has arrived.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pins_pending != 0);
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// New timing setting. The sequencer is run to idle and the pipeline emptied
	// first, so no write ever lands while a byte or wait is in progress. The two
	// unused indexes get random junk that must not disturb anything.
	task automatic program_timing(input logic [15:0] pulse, input logic [15:0] gap,
			input logic [15:0] short_w, input logic [15:0] long_w,
			input logic [15:0] nwait, input logic [15:0] power);
		finish_sequence();
		drain();
		put_reg(REG_ENABLE_PULSE, pulse);
		put_reg(REG_NIBBLE_GAP, gap);
		put_reg(REG_SHORT_WAIT, short_w);
		put_reg(REG_LONG_WAIT, long_w);
		put_reg(REG_INIT_NWAIT, nwait);
		put_reg(REG_POWER_UP, power);
		put_reg(REG_SPARE_LO, 16'($urandom_range(65535)));
		put_reg(REG_SPARE_HI, 16'($urandom_range(65535)));
		cfg_wr_en <= 1'b0;
	endtask

	// Random tick: mostly requests with random content, with plain ticks and
	// meaningless modes mixed in. Clear and home are favored among commands
	// because they select the long wait.
	task automatic random_item();
		int         pick;
		logic [2:0] mode;
		logic [7:0] bv;
		pick = $urandom_range(99);
		bv   = 8'($urandom_range(255));
		if (pick < 35) begin
			mode = MODE_TICK;
		end else if (pick < 55) begin
			mode = MODE_DATA;
		end else if (pick < 75) begin
			mode = MODE_CMD;
			if ($urandom_range(3) == 0)
				bv = $urandom_range(1) ? CMD_CLEAR : CMD_HOME;
		end else if (pick < 88) begin
			mode = MODE_CURSOR;
		end else if (pick < 93) begin
			mode = MODE_INIT;
		end else begin
			mode = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
		end
		send_item(mode, bv, 2'($urandom_range(3)), 6'($urandom_range(63)));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Timing registers at their reset values: one data byte with its enable
		// pulses, nibble gaps and short wait.
		send_item(MODE_DATA, 8'hA5, 2'd0, 6'd0);
		finish_sequence();

		// Every time at zero; the enable pulse must still last one tick and all
		// other phases vanish. Requests go back to back, so some hit a busy
		// controller and some land on the tick where a sequence ends.
		program_timing('0, '0, '0, '0, '0, '0);
		send_item(MODE_INIT, 8'h00, 2'd0, 6'd0);
		finish_sequence();
		send_item(MODE_DATA, 8'h00, 2'd0, 6'd0);
		send_item(MODE_DATA, 8'hFF, 2'd0, 6'd0);
		send_item(MODE_DATA, CMD_CLEAR, 2'd0, 6'd0);
		send_item(MODE_DATA, CMD_HOME, 2'd0, 6'd0);
		finish_sequence();
		send_item(MODE_CMD, 8'h00, 2'd0, 6'd0);
		send_item(MODE_CMD, 8'hFF, 2'd0, 6'd0);
		send_item(MODE_CMD, CMD_CLEAR, 2'd0, 6'd0);
		send_item(MODE_CMD, CMD_HOME, 2'd0, 6'd0);
		finish_sequence();
		send_item(MODE_CURSOR, 8'h00, 2'd0, 6'd0);
		send_item(MODE_CURSOR, 8'hFF, 2'd1, 6'd39);
		send_item(MODE_CURSOR, 8'h00, 2'd2, 6'd63);
		send_item(MODE_CURSOR, 8'hFF, 2'd3, 6'd63);
		finish_sequence();
		send_item(MODE_SPARE_FIRST, 8'hFF, 2'd3, 6'd63);
		send_item(MODE_SPARE_MID, 8'h00, 2'd0, 6'd0);
		send_item(MODE_SPARE_LAST, 8'h5A, 2'd2, 6'd21);

		// Small nonzero times with a full init and a cursor move.
		program_timing(16'd2, 16'd1, 16'd3, 16'd5, 16'd2, 16'd4);
		send_item(MODE_INIT, 8'h00, 2'd0, 6'd0);
		finish_sequence();
		send_item(MODE_CURSOR, 8'h80, 2'd3, 6'd39);

		// Random part: eight timing settings with short times so that most
		// requests find the controller idle soon, one of them with no idling.
		for (int setting = 0; setting < 8; setting++) begin
			program_timing(16'($urandom_range(3)), 16'($urandom_range(4)),
				16'($urandom_range(6)), 16'($urandom_range(12)),
				16'($urandom_range(6)), 16'($urandom_range(20)));
			calm = (setting == 5);
			for (int n = 0; n < 140; n++)
				random_item();
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pins_pending == 0)
			$display("[char_lcd_nibble_writer] OK");
		else
			$display("[char_lcd_nibble_writer] ERROR");
		$finish;
	end

	// Watchdog, many times the length of the slowest correct run.
	initial begin
		#1200000;
		$display("[char_lcd_nibble_writer] ERROR");
		$finish;
	end

endmodule
